// ===== src/lsw_pkg.sv =====
// Shared types, constants and register map for the lidar sector wall follower.
`default_nettype none
package lsw_pkg;

	// Sizes
	localparam int MAX_SAMPLES = 1024;
	localparam int RANGE_W     = 16;
	localparam int WIN_W       = 10;
	localparam int SUM_W       = 26;
	localparam int CNT_W       = 11;
	localparam int SPEED_W     = 8;
	localparam int TURN_W      = 11;
	localparam int CFG_N       = 8;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;
	localparam int DIV_N       = SUM_W;
	localparam int STEP_W      = $clog2(DIV_N);

	// Saturation limits and command values
	localparam logic [SUM_W-1:0]          SUM_MAX     = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0]          CNT_MAX     = {CNT_W{1'b1}};
	localparam logic [RANGE_W-1:0]        FMIN_RESET  = {RANGE_W{1'b1}};
	localparam logic [SPEED_W-1:0]        DRIVE_SPEED = 8'd150;
	localparam logic [SPEED_W-1:0]        STOP_SPEED  = 8'd0;
	localparam int                        TURN_LIMIT  = 1000;
	localparam logic signed [TURN_W-1:0]  TURN_LEFT   = 11'sd1000;
	localparam logic signed [TURN_W-1:0]  TURN_RIGHT  = -11'sd1000;

	// Register reset values
	localparam logic [WIN_W-1:0]   FRONT_START_RST = 10'd994;
	localparam logic [WIN_W-1:0]   FRONT_END_RST   = 10'd30;
	localparam logic [WIN_W-1:0]   LEFT_START_RST  = 10'd249;
	localparam logic [WIN_W-1:0]   LEFT_END_RST    = 10'd279;
	localparam logic [WIN_W-1:0]   RIGHT_START_RST = 10'd753;
	localparam logic [WIN_W-1:0]   RIGHT_END_RST   = 10'd783;
	localparam logic [RANGE_W-1:0] STOP_DIST_RST   = 16'd250;
	localparam logic [RANGE_W-1:0] CLIP_DIST_RST   = 16'd400;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_FRONT_START = 3'd0,
		REG_FRONT_END   = 3'd1,
		REG_LEFT_START  = 3'd2,
		REG_LEFT_END    = 3'd3,
		REG_RIGHT_START = 3'd4,
		REG_RIGHT_END   = 3'd5,
		REG_STOP_DIST   = 3'd6,
		REG_CLIP_DIST   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [WIN_W-1:0]   front_start;
		logic [WIN_W-1:0]   front_end;
		logic [WIN_W-1:0]   left_start;
		logic [WIN_W-1:0]   left_end;
		logic [WIN_W-1:0]   right_start;
		logic [WIN_W-1:0]   right_end;
		logic [RANGE_W-1:0] stop_distance;
		logic [RANGE_W-1:0] clip_distance;
	} cfg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_INIT_L,
		ST_DIV_L,
		ST_INIT_R,
		ST_DIV_R,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic snap;
		logic div_init;
		logic div_sel;
		logic div_step;
		logic save_left;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== src/lsw_if.sv =====
// Request channel interfaces for lidar samples and drive commands.
`default_nettype none
interface lsw_in_if;
	logic                         valid;
	logic                         ready;
	logic [lsw_pkg::RANGE_W-1:0]  range_mm;
	logic                         range_valid;
	logic                         last_sample;

	modport source (output valid, output range_mm, output range_valid,
		output last_sample, input ready);
	modport sink (input valid, input range_mm, input range_valid,
		input last_sample, output ready);
endinterface

interface lsw_out_if;
	logic                               valid;
	logic                               ready;
	logic [lsw_pkg::SPEED_W-1:0]        linear_speed;
	logic signed [lsw_pkg::TURN_W-1:0]  turn_rate;
	logic                               obstacle_ahead;

	modport source (output valid, output linear_speed, output turn_rate,
		output obstacle_ahead, input ready);
	modport sink (input valid, input linear_speed, input turn_rate,
		input obstacle_ahead, output ready);
endinterface
`default_nettype wire

// ===== src/lsw_regs.sv =====
// APB configuration register file for the wall follower.
`default_nettype none
module lsw_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lsw_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [lsw_pkg::PDATA_W-1:0]   pwdata,
	output logic      [lsw_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output lsw_pkg::cfg_t                      cfg
);

	lsw_pkg::cfg_t     cfg_q;
	lsw_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx   = lsw_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg   = cfg_q;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_start   <= lsw_pkg::FRONT_START_RST;
			cfg_q.front_end     <= lsw_pkg::FRONT_END_RST;
			cfg_q.left_start    <= lsw_pkg::LEFT_START_RST;
			cfg_q.left_end      <= lsw_pkg::LEFT_END_RST;
			cfg_q.right_start   <= lsw_pkg::RIGHT_START_RST;
			cfg_q.right_end     <= lsw_pkg::RIGHT_END_RST;
			cfg_q.stop_distance <= lsw_pkg::STOP_DIST_RST;
			cfg_q.clip_distance <= lsw_pkg::CLIP_DIST_RST;
		end else if (wr_en) begin
			unique case (idx)
				lsw_pkg::REG_FRONT_START: cfg_q.front_start <= pwdata[lsw_pkg::WIN_W-1:0];
				lsw_pkg::REG_FRONT_END:   cfg_q.front_end   <= pwdata[lsw_pkg::WIN_W-1:0];
				lsw_pkg::REG_LEFT_START:  cfg_q.left_start  <= pwdata[lsw_pkg::WIN_W-1:0];
				lsw_pkg::REG_LEFT_END:    cfg_q.left_end    <= pwdata[lsw_pkg::WIN_W-1:0];
				lsw_pkg::REG_RIGHT_START: cfg_q.right_start <= pwdata[lsw_pkg::WIN_W-1:0];
				lsw_pkg::REG_RIGHT_END:   cfg_q.right_end   <= pwdata[lsw_pkg::WIN_W-1:0];
				lsw_pkg::REG_STOP_DIST:   cfg_q.stop_distance <= pwdata[lsw_pkg::RANGE_W-1:0];
				lsw_pkg::REG_CLIP_DIST:   cfg_q.clip_distance <= pwdata[lsw_pkg::RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			lsw_pkg::REG_FRONT_START: prdata = lsw_pkg::PDATA_W'(cfg_q.front_start);
			lsw_pkg::REG_FRONT_END:   prdata = lsw_pkg::PDATA_W'(cfg_q.front_end);
			lsw_pkg::REG_LEFT_START:  prdata = lsw_pkg::PDATA_W'(cfg_q.left_start);
			lsw_pkg::REG_LEFT_END:    prdata = lsw_pkg::PDATA_W'(cfg_q.left_end);
			lsw_pkg::REG_RIGHT_START: prdata = lsw_pkg::PDATA_W'(cfg_q.right_start);
			lsw_pkg::REG_RIGHT_END:   prdata = lsw_pkg::PDATA_W'(cfg_q.right_end);
			lsw_pkg::REG_STOP_DIST:   prdata = lsw_pkg::PDATA_W'(cfg_q.stop_distance);
			lsw_pkg::REG_CLIP_DIST:   prdata = lsw_pkg::PDATA_W'(cfg_q.clip_distance);
			default:                  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/lsw_ctrl.sv =====
// Controller: sequences sample intake, the two side divisions and the result load.
`default_nettype none
module lsw_ctrl (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_last,
	output logic         in_ready,
	input  lsw_pkg::sts_t sts,
	output lsw_pkg::cmd_t cmd
);

	localparam logic [lsw_pkg::STEP_W-1:0] STEP_LAST = lsw_pkg::STEP_W'(lsw_pkg::DIV_N - 1);

	lsw_pkg::state_t             state_q, state_d;
	logic [lsw_pkg::STEP_W-1:0]  step_q;
	logic                        step_end;

	assign step_end = (step_q == STEP_LAST);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsw_pkg::ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	// Division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_init) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsw_pkg::ST_ACCUM:  if (in_valid && in_last) state_d = lsw_pkg::ST_INIT_L;
			lsw_pkg::ST_INIT_L: state_d = lsw_pkg::ST_DIV_L;
			lsw_pkg::ST_DIV_L:  if (step_end) state_d = lsw_pkg::ST_INIT_R;
			lsw_pkg::ST_INIT_R: state_d = lsw_pkg::ST_DIV_R;
			lsw_pkg::ST_DIV_R:  if (step_end) state_d = lsw_pkg::ST_DONE;
			lsw_pkg::ST_DONE:   if (!sts.out_busy) state_d = lsw_pkg::ST_ACCUM;
			default:            state_d = lsw_pkg::ST_ACCUM;
		endcase
	end

	// Commands
	always_comb begin
		in_ready      = (state_q == lsw_pkg::ST_ACCUM);
		cmd.take      = in_ready && in_valid;
		cmd.snap      = in_ready && in_valid && in_last;
		cmd.div_init  = (state_q == lsw_pkg::ST_INIT_L) || (state_q == lsw_pkg::ST_INIT_R);
		cmd.div_sel   = (state_q == lsw_pkg::ST_INIT_R);
		cmd.div_step  = (state_q == lsw_pkg::ST_DIV_L) || (state_q == lsw_pkg::ST_DIV_R);
		cmd.save_left = (state_q == lsw_pkg::ST_INIT_R);
		cmd.load_out  = (state_q == lsw_pkg::ST_DONE) && !sts.out_busy;
	end

	a_last_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap |=> state_q == lsw_pkg::ST_INIT_L)
		else $error("last sample did not start division");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lsw_pkg::ST_DIV_L && step_end) |=> state_q == lsw_pkg::ST_INIT_R)
		else $error("left division overran");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == lsw_pkg::ST_ACCUM)
		else $error("result load did not return to intake");

endmodule
`default_nettype wire

// ===== src/lsw_dp.sv =====
// Datapath: window accumulation, shared restoring divider and command formation.
`default_nettype none
module lsw_dp #(
	parameter int MAX_SAMPLES = lsw_pkg::MAX_SAMPLES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  lsw_pkg::cfg_t                            cfg,
	input  lsw_pkg::cmd_t                            cmd,
	output lsw_pkg::sts_t                            sts,
	input  wire logic [lsw_pkg::RANGE_W-1:0]         range_mm,
	input  wire logic                                range_valid,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [lsw_pkg::SPEED_W-1:0]              linear_speed,
	output logic signed [lsw_pkg::TURN_W-1:0]        turn_rate,
	output logic                                     obstacle_ahead
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CMP_W = (IDX_W > lsw_pkg::WIN_W) ? IDX_W : lsw_pkg::WIN_W;
	localparam int SW    = lsw_pkg::SUM_W;
	localparam int CW    = lsw_pkg::CNT_W;
	localparam int RW    = lsw_pkg::RANGE_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);
	localparam logic signed [SW:0] LIM_HI = (SW + 1)'(lsw_pkg::TURN_LIMIT);
	localparam logic signed [SW:0] LIM_LO = -((SW + 1)'(lsw_pkg::TURN_LIMIT));

	function automatic logic in_win(input logic [CMP_W-1:0] i, input logic [CMP_W-1:0] s,
		input logic [CMP_W-1:0] e);
		if (s <= e) begin
			return (i >= s) && (i <= e);
		end
		return (i >= s) || (i <= e);
	endfunction

	// Scan accumulators
	logic [IDX_W-1:0] idx_q;
	logic [RW-1:0]    fmin_q;
	logic [SW-1:0]    lsum_q, rsum_q;
	logic [CW-1:0]    lcnt_q, rcnt_q;

	// End-of-scan snapshot
	logic [RW-1:0]    fmin_snap_q;
	logic [SW-1:0]    lsum_snap_q, rsum_snap_q;
	logic [CW-1:0]    lcnt_snap_q, rcnt_snap_q;

	// Divider
	logic [SW-1:0]    quo_q;
	logic [CW-1:0]    rem_q, dvs_q;
	logic [SW-1:0]    lquo_q;

	// Output register
	logic                      out_valid_q;
	logic [lsw_pkg::SPEED_W-1:0] speed_q;
	logic signed [lsw_pkg::TURN_W-1:0] turn_q;
	logic                      obst_q;

	logic              used, hit_f, hit_l, hit_r;
	logic [RW-1:0]     clipped, fmin_d;
	logic [SW:0]       lsum_add, rsum_add;
	logic [SW-1:0]     lsum_d, rsum_d;
	logic [CW-1:0]     lcnt_d, rcnt_d;
	logic [CW:0]       shifted;
	logic [CW+1:0]     trial;
	logic              qbit;
	logic [SW-1:0]     lavg, ravg;
	logic signed [SW:0] diff_s, half_s;
	logic signed [lsw_pkg::TURN_W-1:0] steer;
	logic              obst_d;

	// Classify the sample and form next accumulator values
	always_comb begin
		used    = range_valid && (range_mm != '0);
		clipped = (range_mm > cfg.clip_distance) ? cfg.clip_distance : range_mm;
		hit_f   = used && in_win(CMP_W'(idx_q), CMP_W'(cfg.front_start), CMP_W'(cfg.front_end));
		hit_l   = used && in_win(CMP_W'(idx_q), CMP_W'(cfg.left_start), CMP_W'(cfg.left_end));
		hit_r   = used && in_win(CMP_W'(idx_q), CMP_W'(cfg.right_start), CMP_W'(cfg.right_end));
		fmin_d  = (hit_f && (range_mm < fmin_q)) ? range_mm : fmin_q;
		lsum_add = {1'b0, lsum_q} + (SW + 1)'(clipped);
		rsum_add = {1'b0, rsum_q} + (SW + 1)'(clipped);
		lsum_d  = lsum_q;
		lcnt_d  = lcnt_q;
		rsum_d  = rsum_q;
		rcnt_d  = rcnt_q;
		if (hit_l) begin
			lsum_d = lsum_add[SW] ? lsw_pkg::SUM_MAX : lsum_add[SW-1:0];
			lcnt_d = (lcnt_q == lsw_pkg::CNT_MAX) ? lcnt_q : lcnt_q + 1'b1;
		end
		if (hit_r) begin
			rsum_d = rsum_add[SW] ? lsw_pkg::SUM_MAX : rsum_add[SW-1:0];
			rcnt_d = (rcnt_q == lsw_pkg::CNT_MAX) ? rcnt_q : rcnt_q + 1'b1;
		end
	end

	// Accumulate samples; clear on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			fmin_q <= lsw_pkg::FMIN_RESET;
			lsum_q <= '0;
			lcnt_q <= '0;
			rsum_q <= '0;
			rcnt_q <= '0;
		end else if (cmd.snap) begin
			idx_q  <= '0;
			fmin_q <= lsw_pkg::FMIN_RESET;
			lsum_q <= '0;
			lcnt_q <= '0;
			rsum_q <= '0;
			rcnt_q <= '0;
		end else if (cmd.take) begin
			idx_q  <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			fmin_q <= fmin_d;
			lsum_q <= lsum_d;
			lcnt_q <= lcnt_d;
			rsum_q <= rsum_d;
			rcnt_q <= rcnt_d;
		end
	end

	// Hold the finished scan for the divider
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			fmin_snap_q <= fmin_d;
			lsum_snap_q <= lsum_d;
			lcnt_snap_q <= lcnt_d;
			rsum_snap_q <= rsum_d;
			rcnt_snap_q <= rcnt_d;
		end
	end

	// Restoring divider, one quotient bit a cycle
	always_comb begin
		shifted = {rem_q, quo_q[SW-1]};
		trial   = {1'b0, shifted} - {2'b0, dvs_q};
		qbit    = !trial[CW+1];
	end

	always_ff @(posedge clk) begin
		if (cmd.save_left) begin
			lquo_q <= quo_q;
		end
		if (cmd.div_init) begin
			quo_q <= cmd.div_sel ? rsum_snap_q : lsum_snap_q;
			dvs_q <= cmd.div_sel ? rcnt_snap_q : lcnt_snap_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SW-2:0], qbit};
			rem_q <= qbit ? trial[CW-1:0] : shifted[CW-1:0];
		end
	end

	// Form the drive command from the side averages
	always_comb begin
		lavg   = (lcnt_snap_q == '0) ? SW'(cfg.clip_distance) : lquo_q;
		ravg   = (rcnt_snap_q == '0) ? SW'(cfg.clip_distance) : quo_q;
		obst_d = (fmin_snap_q < cfg.stop_distance);
		diff_s = $signed({1'b0, lavg}) - $signed({1'b0, ravg});
		half_s = (diff_s + $signed({{SW{1'b0}}, diff_s[SW]})) >>> 1;
		if (half_s > LIM_HI) begin
			steer = lsw_pkg::TURN_LEFT;
		end else if (half_s < LIM_LO) begin
			steer = lsw_pkg::TURN_RIGHT;
		end else begin
			steer = half_s[lsw_pkg::TURN_W-1:0];
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			obst_q <= obst_d;
			if (obst_d) begin
				speed_q <= lsw_pkg::STOP_SPEED;
				turn_q  <= (lavg >= ravg) ? lsw_pkg::TURN_LEFT : lsw_pkg::TURN_RIGHT;
			end else begin
				speed_q <= lsw_pkg::DRIVE_SPEED;
				turn_q  <= steer;
			end
		end
	end

	assign sts.out_busy   = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign linear_speed   = speed_q;
	assign turn_rate      = turn_q;
	assign obstacle_ahead = obst_q;

	a_snap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap |=> (fmin_q == lsw_pkg::FMIN_RESET) && (lcnt_q == '0) && (rcnt_q == '0))
		else $error("scan state not cleared after last sample");

	a_cnt_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !cmd.snap) |=> (lcnt_q >= $past(lcnt_q)) && (rcnt_q >= $past(rcnt_q)))
		else $error("side count went down within a scan");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && (dvs_q != '0)) |=> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

// ===== src/lidar_sector_wall_follow.sv =====
// Top level of the lidar sector wall follower.
// Takes one range sample per cycle on the samples channel, numbering them from
// zero within a scan (wrapping at MAX_SAMPLES). Valid, nonzero samples lower the
// front-window minimum and add clipped ranges into the left and right window
// sums. The sample marked last closes the scan: the block then stops taking
// samples while one shared restoring divider works out the left and then the
// right side average (a setup state and a division state per side, then a
// load state held until the prior command is taken). The resulting speed
// and turn command sits in an output register, so sampling of the next scan
// resumes while that command waits. Windows, stop and clip distances are set
// through the APB registers at byte addresses 0x00 to 0x1C and should be
// written only between scans.
`default_nettype none
module lidar_sector_wall_follow #(
	parameter int MAX_SAMPLES = lsw_pkg::MAX_SAMPLES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	lsw_in_if.sink                            samples,
	lsw_out_if.source                         commands,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lsw_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [lsw_pkg::PDATA_W-1:0]  pwdata,
	output logic      [lsw_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);

	lsw_pkg::cfg_t cfg;
	lsw_pkg::cmd_t cmd;
	lsw_pkg::sts_t sts;
	logic          in_ready;

	assign samples.ready = in_ready;

	// Configuration registers
	lsw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	lsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (samples.last_sample),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Accumulators, divider and result register
	lsw_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.range_mm       (samples.range_mm),
		.range_valid    (samples.range_valid),
		.out_valid      (commands.valid),
		.out_ready      (commands.ready),
		.linear_speed   (commands.linear_speed),
		.turn_rate      (commands.turn_rate),
		.obstacle_ahead (commands.obstacle_ahead)
	);

endmodule
`default_nettype wire
